@@ src/vpb_pkg.sv @@
// ----------------------------------------------------------------------------
// vpb_pkg
// Shared types and constants for the vertical page bitmap blitter.
// ----------------------------------------------------------------------------
package vpb_pkg;

  localparam int MEM_BYTES = 2048;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int PAGE_ROWS = 8;
  localparam int PAGE_W    = $clog2(PAGE_ROWS);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_COPY  = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_SOURCE_BASE   = 2'd0,
    CFG_SOURCE_STRIDE = 2'd1,
    CFG_DEST_BASE     = 2'd2,
    CFG_DEST_STRIDE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEMRD,
    S_BAND,
    S_SRC,
    S_DST,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              is_fill;
    logic              polarity;
    logic [PAGE_W-1:0] sob;
    logic [PAGE_W-1:0] dob;
    logic [7:0]        smsk;
    logic [7:0]        dmsk;
  } merge_ctl_t;

endpackage

@@ src/vpb_ram.sv @@
// ----------------------------------------------------------------------------
// vpb_ram
// Single port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/vpb_merge.sv @@
// ----------------------------------------------------------------------------
// vpb_merge
// Aligns masked source bits to the destination page offset and merges them
// into the destination byte; fill sets or clears the band mask.
// ----------------------------------------------------------------------------
module vpb_merge
  import vpb_pkg::*;
(
  input  merge_ctl_t ctl,
  input  logic [7:0] src_byte,
  input  logic [7:0] dst_byte,
  output logic [7:0] new_byte
);

  logic [7:0] src_pol;
  logic [7:0] src_sel;
  logic [7:0] src_aligned;

  always_comb begin
    src_pol = ctl.polarity ? ~src_byte : src_byte;
    src_sel = src_pol & ctl.smsk;
    if (ctl.dob >= ctl.sob) begin
      src_aligned = src_sel << (ctl.dob - ctl.sob);
    end else begin
      src_aligned = src_sel >> (ctl.sob - ctl.dob);
    end
    if (ctl.is_fill) begin
      new_byte = ctl.polarity ? (dst_byte | ~ctl.dmsk) : (dst_byte & ctl.dmsk);
    end else begin
      new_byte = (dst_byte & ctl.dmsk) | src_aligned;
    end
  end

endmodule

@@ src/vertical_page_bitmap_blitter.sv @@
// ----------------------------------------------------------------------------
// vertical_page_bitmap_blitter
// Copy and fill share the single memory port: per column, copy reads the source,
// then reads and writes the destination; fill reads and writes the destination.
// One request at a time; the next is taken while the result waits.
// Reset (synchronous, rst_n low) clears state and out_valid and sets config to
// source base 0, dest base 1024, both strides 128; memory is unset.
// ----------------------------------------------------------------------------
module vertical_page_bitmap_blitter
  import vpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [10:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_src_x,
  input  logic [7:0]  in_src_y,
  input  logic [7:0]  in_dst_x,
  input  logic [7:0]  in_dst_y,
  input  logic [7:0]  in_width,
  input  logic [7:0]  in_height,
  input  logic        in_polarity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_done_command,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  state_t state_r, state_nxt;
  logic [10:0] source_base_r, dest_base_r;
  logic [7:0]  source_stride_r, dest_stride_r;
  logic        out_valid_r, out_valid_nxt;

  cmd_t              cmd_r, cmd_nxt;
  logic              pol_r, pol_nxt;
  logic [7:0]        width_r, width_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [PAGE_W-1:0] sob_r, sob_nxt, dob_r, dob_nxt;
  logic [10:0]       src_row_r, src_row_nxt, dst_row_r, dst_row_nxt;
  logic [3:0]        rows_r, rows_nxt;
  logic [7:0]        smsk_r, smsk_nxt, dmsk_r, dmsk_nxt;
  logic [7:0]        src_byte_r, src_byte_nxt;
  logic [7:0]        rd_r, rd_nxt;
  logic [7:0]        out_read_data_r;
  logic [1:0]        out_done_command_r;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic              accept;
  logic [12:0]       src_page_off, dst_page_off;
  logic [10:0]       src_addr, dst_addr;
  logic [PAGE_W-1:0] max_off;
  logic [3:0]        band_rows, rows_sel;
  logic [8:0]        msk9;
  logic [7:0]        msk;
  logic [PAGE_W:0]   sob_sum, dob_sum;
  merge_ctl_t        mctl;
  logic [7:0]        merged;

  vpb_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign mctl = '{is_fill: (cmd_r == CMD_FILL), polarity: pol_r, sob: sob_r, dob: dob_r,
                  smsk: smsk_r, dmsk: dmsk_r};

  vpb_merge u_merge (
    .ctl      (mctl),
    .src_byte (src_byte_r),
    .dst_byte (ram_rdata),
    .new_byte (merged)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign src_page_off = 13'(in_src_y[7:PAGE_W]) * 13'(source_stride_r);
  assign dst_page_off = 13'(in_dst_y[7:PAGE_W]) * 13'(dest_stride_r);
  assign src_addr     = src_row_r + 11'(col_r);
  assign dst_addr     = dst_row_r + 11'(col_r);

  always_comb begin
    if (cmd_r == CMD_FILL || dob_r >= sob_r) begin
      max_off = dob_r;
    end else begin
      max_off = sob_r;
    end
    band_rows = 4'(PAGE_ROWS) - 4'(max_off);
    rows_sel  = (rem_r < 8'(band_rows)) ? rem_r[3:0] : band_rows;
    msk9      = (9'h1 << rows_sel) - 9'h1;
    msk       = msk9[7:0];
    sob_sum   = {1'b0, sob_r} + rows_r;
    dob_sum   = {1'b0, dob_r} + rows_r;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    pol_nxt       = pol_r;
    width_nxt     = width_r;
    rem_nxt       = rem_r;
    col_nxt       = col_r;
    sob_nxt       = sob_r;
    dob_nxt       = dob_r;
    src_row_nxt   = src_row_r;
    dst_row_nxt   = dst_row_r;
    rows_nxt      = rows_r;
    smsk_nxt      = smsk_r;
    dmsk_nxt      = dmsk_r;
    src_byte_nxt  = src_byte_r;
    rd_nxt        = rd_r;
    ram_we        = 1'b0;
    ram_addr      = MEM_AW'(dst_addr);
    ram_wdata     = merged;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = cmd_t'(in_command);
          pol_nxt     = in_polarity;
          width_nxt   = in_width;
          rem_nxt     = in_height;
          col_nxt     = '0;
          sob_nxt     = (cmd_t'(in_command) == CMD_FILL) ? '0 : in_src_y[PAGE_W-1:0];
          dob_nxt     = in_dst_y[PAGE_W-1:0];
          src_row_nxt = source_base_r + 11'(in_src_x) + src_page_off[10:0];
          dst_row_nxt = dest_base_r + 11'(in_dst_x) + dst_page_off[10:0];
          rd_nxt      = '0;
          ram_addr    = MEM_AW'(in_address);
          ram_wdata   = in_data;
          unique case (cmd_t'(in_command))
            CMD_WRITE: begin
              ram_we    = 1'b1;
              state_nxt = S_DONE;
            end
            CMD_READ: state_nxt = S_MEMRD;
            CMD_COPY, CMD_FILL: state_nxt = S_BAND;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MEMRD: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end
      S_BAND: begin
        rows_nxt = rows_sel;
        smsk_nxt = msk << sob_r;
        dmsk_nxt = ~(msk << dob_r);
        col_nxt  = '0;
        if (rem_r == '0 || width_r == '0) begin
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_FILL) begin
          state_nxt = S_DST;
        end else begin
          state_nxt = S_SRC;
        end
      end
      S_SRC: begin
        ram_addr  = MEM_AW'(src_addr);
        state_nxt = S_DST;
      end
      S_DST: begin
        src_byte_nxt = ram_rdata;
        state_nxt    = S_WR;
      end
      S_WR: begin
        ram_we = 1'b1;
        if (col_r == width_r - 8'd1) begin
          col_nxt = '0;
          rem_nxt = rem_r - 8'(rows_r);
          sob_nxt = sob_sum[PAGE_W-1:0];
          dob_nxt = dob_sum[PAGE_W-1:0];
          if (sob_sum[PAGE_W]) begin
            src_row_nxt = src_row_r + 11'(source_stride_r);
          end
          if (dob_sum[PAGE_W]) begin
            dst_row_nxt = dst_row_r + 11'(dest_stride_r);
          end
          state_nxt = S_BAND;
        end else begin
          col_nxt   = col_r + 8'd1;
          state_nxt = (cmd_r == CMD_FILL) ? S_DST : S_SRC;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      source_base_r   <= 11'd0;
      source_stride_r <= 8'd128;
      dest_base_r     <= 11'd1024;
      dest_stride_r   <= 8'd128;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SOURCE_BASE:   source_base_r   <= cfg_wdata;
          CFG_SOURCE_STRIDE: source_stride_r <= cfg_wdata[7:0];
          CFG_DEST_BASE:     dest_base_r     <= cfg_wdata;
          CFG_DEST_STRIDE:   dest_stride_r   <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pol_r      <= pol_nxt;
    width_r    <= width_nxt;
    rem_r      <= rem_nxt;
    col_r      <= col_nxt;
    sob_r      <= sob_nxt;
    dob_r      <= dob_nxt;
    src_row_r  <= src_row_nxt;
    dst_row_r  <= dst_row_nxt;
    rows_r     <= rows_nxt;
    smsk_r     <= smsk_nxt;
    dmsk_r     <= dmsk_nxt;
    src_byte_r <= src_byte_nxt;
    rd_r       <= rd_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_read_data_r    <= rd_r;
      out_done_command_r <= cmd_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_done_command = out_done_command_r;

`ifndef SYNTH
  a_we_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_WR) || (accept && in_command == CMD_WRITE))
    else $error("memory write outside a write request or merge cycle");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRC || state_r == S_DST || state_r == S_WR) |-> (col_r < width_r))
    else $error("column counter beyond rectangle width");

  a_band_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BAND && rem_r != '0) |=> (rows_r != '0 && rows_r <= 4'(PAGE_ROWS)))
    else $error("band row count out of range");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready)) |=> (out_valid && state_r == S_IDLE))
    else $error("finished request did not reach the result register");
`endif

endmodule

@@ tb/vpb_done_checker.sv @@
// ----------------------------------------------------------------------------
// vpb_done_checker
// Watches the request, result and config ports of the blitter. Keeps its own
// copy of the pixel memory and config registers, predicts the completion of
// every accepted request and compares each accepted result, field by field,
// with the oldest prediction. Counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
module vpb_done_checker
  import vpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [10:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_src_x,
  input  logic [7:0]  in_src_y,
  input  logic [7:0]  in_dst_x,
  input  logic [7:0]  in_dst_y,
  input  logic [7:0]  in_width,
  input  logic [7:0]  in_height,
  input  logic        in_polarity,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic [1:0]  out_done_command,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  output int unsigned mismatches,
  output int unsigned pending
);

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] done_command;
  } done_t;

  logic [7:0]  pix [MEM_BYTES];
  logic [10:0] src_base;
  logic [7:0]  src_stride;
  logic [10:0] dst_base;
  logic [7:0]  dst_stride;
  done_t       expected_done [$];

  function automatic logic [10:0] page_byte(logic [10:0] base, int unsigned x, int unsigned y,
                                            logic [7:0] stride, int unsigned col);
    return 11'((base + x + (y / PAGE_ROWS) * stride + col) % MEM_BYTES);
  endfunction

  task automatic copy_rect(int unsigned sx, int unsigned sy, int unsigned dx, int unsigned dy,
                           int unsigned w, int unsigned h, logic invert);
    int unsigned rows_done, sob, dob, rows, col;
    logic [10:0] sa, da;
    logic [7:0]  msk, smsk, dmsk, s, v;
    rows_done = 0;
    while (rows_done < h) begin
      sob = sy % PAGE_ROWS;
      dob = dy % PAGE_ROWS;
      rows = PAGE_ROWS - ((sob > dob) ? sob : dob);
      if (rows_done + rows > h) rows = h - rows_done;
      msk  = 8'((1 << rows) - 1);
      smsk = msk << sob;
      dmsk = ~(msk << dob);
      for (col = 0; col < w; col++) begin
        sa = page_byte(src_base, sx, sy, src_stride, col);
        da = page_byte(dst_base, dx, dy, dst_stride, col);
        s  = invert ? ~pix[sa] : pix[sa];
        v  = s & smsk;
        v  = (dob >= sob) ? v << (dob - sob) : v >> (sob - dob);
        pix[da] = (pix[da] & dmsk) | v;
      end
      rows_done += rows;
      sy += rows;
      dy += rows;
    end
  endtask

  task automatic fill_rect(int unsigned dx, int unsigned dy, int unsigned w, int unsigned h,
                           logic set);
    int unsigned rows_done, dob, rows, col;
    logic [10:0] da;
    logic [7:0]  msk;
    rows_done = 0;
    while (rows_done < h) begin
      dob = dy % PAGE_ROWS;
      rows = PAGE_ROWS - dob;
      if (rows_done + rows > h) rows = h - rows_done;
      msk = 8'(((1 << rows) - 1) << dob);
      for (col = 0; col < w; col++) begin
        da = page_byte(dst_base, dx, dy, dst_stride, col);
        pix[da] = set ? (pix[da] | msk) : (pix[da] & ~msk);
      end
      rows_done += rows;
      dy += rows;
    end
  endtask

  task automatic note_mismatch(string what, done_t want, done_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected read_data=%02h command=%0d, got read_data=%02h command=%0d",
               $realtime, what, want.read_data, want.done_command,
               got.read_data, got.done_command);
  endtask

  always @(posedge clk) begin
    done_t      want;
    done_t      got;
    logic [7:0] rd;
    if (!rst_n) begin
      src_base   = 11'd0;
      src_stride = 8'd128;
      dst_base   = 11'd1024;
      dst_stride = 8'd128;
      mismatches = 0;
      expected_done.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{read_data: out_read_data, done_command: out_done_command};
        if (expected_done.size() == 0) begin
          note_mismatch("result with no request pending", '0, got);
        end else begin
          want = expected_done.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SOURCE_BASE:   src_base   = cfg_wdata;
          CFG_SOURCE_STRIDE: src_stride = cfg_wdata[7:0];
          CFG_DEST_BASE:     dst_base   = cfg_wdata;
          CFG_DEST_STRIDE:   dst_stride = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        rd = 8'd0;
        case (cmd_t'(in_command))
          CMD_WRITE: pix[in_address] = in_data;
          CMD_READ:  rd = pix[in_address];
          CMD_COPY:  copy_rect(in_src_x, in_src_y, in_dst_x, in_dst_y,
                               in_width, in_height, in_polarity);
          default:   fill_rect(in_dst_x, in_dst_y, in_width, in_height, in_polarity);
        endcase
        expected_done.push_back('{read_data: rd, done_command: in_command});
      end
    end
    pending = expected_done.size();
  end

endmodule

@@ tb/tb_vertical_page_bitmap_blitter.sv @@
// ----------------------------------------------------------------------------
// tb_vertical_page_bitmap_blitter
// Drives byte writes, byte reads, rectangle copies and fills into the blitter
// under several base/stride settings, with random idle bursts on both ports,
// a long result hold-off and a drain pause. Every byte a request touches is
// written first. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_vertical_page_bitmap_blitter;
  import vpb_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int TOTAL_ITEMS = 1550;
  localparam int NUM_PHASES  = 6;

  typedef struct {
    cmd_t        cmd;
    logic [10:0] address;
    logic [7:0]  data;
    logic [7:0]  src_x;
    logic [7:0]  src_y;
    logic [7:0]  dst_x;
    logic [7:0]  dst_y;
    logic [7:0]  width;
    logic [7:0]  height;
    logic        polarity;
  } blit_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [10:0] in_address;
  logic [7:0]  in_data;
  logic [7:0]  in_src_x;
  logic [7:0]  in_src_y;
  logic [7:0]  in_dst_x;
  logic [7:0]  in_dst_y;
  logic [7:0]  in_width;
  logic [7:0]  in_height;
  logic        in_polarity;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic [1:0]  out_done_command;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_wdata;
  int unsigned mismatches;
  int unsigned pending;

  logic [10:0] sh_src_base   = 11'd0;
  logic [7:0]  sh_src_stride = 8'd128;
  logic [10:0] sh_dst_base   = 11'd1024;
  logic [7:0]  sh_dst_stride = 8'd128;
  bit          written [MEM_BYTES];
  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned req_count = 0;
  int unsigned stall_cycles = 0;

  vertical_page_bitmap_blitter DUT (.*);

  vpb_done_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("vertical_page_bitmap_blitter verification failed");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  function automatic blit_req_t any_req();
    blit_req_t r;
    r.cmd      = cmd_t'($urandom_range(0, 3));
    r.address  = 11'($urandom_range(0, MEM_BYTES - 1));
    r.data     = 8'($urandom);
    r.src_x    = 8'($urandom);
    r.src_y    = 8'($urandom);
    r.dst_x    = 8'($urandom);
    r.dst_y    = 8'($urandom);
    r.width    = 8'($urandom);
    r.height   = 8'($urandom);
    r.polarity = 1'($urandom);
    return r;
  endfunction

  function automatic int unsigned rand_extent();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(0, 12);
    if (pick < 98) return $urandom_range(13, 63);
    return $urandom_range(64, 255);
  endfunction

  function automatic logic [10:0] rand_base();
    case ($urandom_range(0, 5))
      0:       return 11'd0;
      1:       return 11'd2047;
      default: return 11'($urandom_range(0, MEM_BYTES - 1));
    endcase
  endfunction

  function automatic logic [10:0] rand_stride_word();
    case ($urandom_range(0, 7))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd255;
      3:       return {3'($urandom_range(1, 7)), 8'($urandom_range(1, 255))};
      default: return 11'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_request(blit_req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    in_valid    = 1'b1;
    in_command  = r.cmd;
    in_address  = r.address;
    in_data     = r.data;
    in_src_x    = r.src_x;
    in_src_y    = r.src_y;
    in_dst_x    = r.dst_x;
    in_dst_y    = r.dst_y;
    in_width    = r.width;
    in_height   = r.height;
    in_polarity = r.polarity;
    do @(posedge clk); while (!in_ready);
    if (r.cmd == CMD_WRITE) written[r.address] = 1'b1;
    req_count++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // write every byte of the rectangle that has not been written yet
  task automatic prime_rect(logic [10:0] base, logic [7:0] stride, int unsigned x,
                            int unsigned y, int unsigned w, int unsigned h);
    int unsigned p, col;
    logic [10:0] a;
    blit_req_t   wr;
    if (w == 0 || h == 0) return;
    for (p = y / PAGE_ROWS; p <= (y + h - 1) / PAGE_ROWS; p++) begin
      for (col = 0; col < w; col++) begin
        a = 11'((base + x + p * stride + col) % MEM_BYTES);
        if (!written[a]) begin
          wr = any_req();
          wr.cmd = CMD_WRITE;
          wr.address = a;
          send_request(wr);
        end
      end
    end
  endtask

  task automatic issue(blit_req_t r);
    case (r.cmd)
      CMD_READ: prime_rect(r.address, 8'd0, 0, 0, 1, 1);
      CMD_COPY: begin
        prime_rect(sh_src_base, sh_src_stride, r.src_x, r.src_y, r.width, r.height);
        prime_rect(sh_dst_base, sh_dst_stride, r.dst_x, r.dst_y, r.width, r.height);
      end
      CMD_FILL: prime_rect(sh_dst_base, sh_dst_stride, r.dst_x, r.dst_y, r.width, r.height);
      default: ;
    endcase
    send_request(r);
  endtask

  // read back random bytes of the destination rectangle
  task automatic probe_dest(blit_req_t r, int unsigned n);
    blit_req_t   rd;
    int unsigned k, col, row;
    if (r.width == 0 || r.height == 0) return;
    for (k = 0; k < n; k++) begin
      col = $urandom_range(0, r.width - 1);
      row = $urandom_range(0, r.height - 1);
      rd = any_req();
      rd.cmd = CMD_READ;
      rd.address = 11'((sh_dst_base + r.dst_x + ((r.dst_y + row) / PAGE_ROWS) * sh_dst_stride
                        + col) % MEM_BYTES);
      issue(rd);
    end
  endtask

  task automatic blit_probe(cmd_t cmd, int unsigned sx, int unsigned sy, int unsigned dx,
                            int unsigned dy, int unsigned w, int unsigned h, logic pol,
                            int unsigned n);
    blit_req_t r;
    r = any_req();
    r.cmd = cmd;
    r.src_x = 8'(sx);
    r.src_y = 8'(sy);
    r.dst_x = 8'(dx);
    r.dst_y = 8'(dy);
    r.width = 8'(w);
    r.height = 8'(h);
    r.polarity = pol;
    issue(r);
    probe_dest(r, n);
  endtask

  task automatic byte_access(cmd_t cmd, logic [10:0] addr, logic [7:0] value);
    blit_req_t r;
    r = any_req();
    r.cmd = cmd;
    r.address = addr;
    r.data = value;
    issue(r);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [10:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      CFG_SOURCE_BASE:   sh_src_base   = value;
      CFG_SOURCE_STRIDE: sh_src_stride = value[7:0];
      CFG_DEST_BASE:     sh_dst_base   = value;
      default:           sh_dst_stride = value[7:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(logic [10:0] sb, logic [10:0] ss, logic [10:0] db,
                            logic [10:0] ds);
    wait_idle();
    write_cfg(CFG_SOURCE_BASE, sb);
    write_cfg(CFG_SOURCE_STRIDE, ss);
    write_cfg(CFG_DEST_BASE, db);
    write_cfg(CFG_DEST_STRIDE, ds);
  endtask

  task automatic random_step();
    blit_req_t   r;
    int unsigned pick;
    r = any_req();
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      r.cmd = $urandom_range(0, 1) ? CMD_COPY : CMD_FILL;
      r.width = 8'(rand_extent());
      r.height = 8'(rand_extent());
      issue(r);
      probe_dest(r, $urandom_range(1, 3));
    end else if (pick < 80) begin
      r.cmd = CMD_WRITE;
      issue(r);
    end else if (pick < 92) begin
      r.cmd = CMD_READ;
      issue(r);
    end else begin
      r.cmd = $urandom_range(0, 1) ? CMD_COPY : CMD_FILL;
      if ($urandom_range(0, 1)) begin
        r.width = 8'd0;
        r.height = 8'(rand_extent());
      end else begin
        r.width = 8'(rand_extent());
        r.height = 8'd0;
      end
      issue(r);
    end
  endtask

  initial begin
    int unsigned phase, start, budget;
    bit          held, paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_WRITE;
    in_address = '0;
    in_data = '0;
    in_src_x = '0;
    in_src_y = '0;
    in_dst_x = '0;
    in_dst_y = '0;
    in_width = '0;
    in_height = '0;
    in_polarity = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SOURCE_BASE;
    cfg_wdata = '0;
    held = 1'b0;
    paused = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    byte_access(CMD_WRITE, 11'd0, 8'hFF);
    byte_access(CMD_WRITE, 11'd2047, 8'h00);
    byte_access(CMD_READ, 11'd2047, 8'h5A);
    byte_access(CMD_READ, 11'd0, 8'hA5);
    blit_probe(CMD_COPY, 0, 3, 5, 6, 4, 9, 1'b0, 2);
    blit_probe(CMD_COPY, 2, 6, 1, 1, 3, 12, 1'b1, 2);
    blit_probe(CMD_FILL, 0, 0, 2, 5, 5, 10, 1'b1, 2);
    blit_probe(CMD_FILL, 0, 0, 3, 0, 2, 8, 1'b0, 1);
    blit_probe(CMD_COPY, 7, 7, 9, 9, 0, 10, 1'b0, 0);
    blit_probe(CMD_FILL, 7, 7, 9, 9, 7, 0, 1'b1, 0);
    blit_probe(CMD_COPY, 255, 255, 255, 255, 1, 1, 1'b0, 1);

    // wrapping bases, zero source stride, widest destination stride
    set_config(11'd2040, 11'd0, 11'd2047, 11'd255);
    blit_probe(CMD_COPY, 10, 4, 0, 3, 20, 20, 1'b1, 2);
    blit_probe(CMD_FILL, 0, 0, 250, 250, 255, 9, 1'b1, 1);

    // fully overlapping bitmaps, largest rectangles
    set_config(11'd0, 11'd1, 11'd0, 11'd1);
    blit_probe(CMD_COPY, 0, 1, 3, 2, 255, 255, 1'b0, 2);
    blit_probe(CMD_FILL, 0, 0, 0, 0, 255, 255, 1'b1, 1);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      set_config(rand_base(), rand_stride_word(), rand_base(), rand_stride_word());
      quiet = (phase == NUM_PHASES - 1);
      start = req_count;
      budget = (req_count < TOTAL_ITEMS) ?
               (TOTAL_ITEMS - req_count) / (NUM_PHASES - phase) : 20;
      if (budget < 20) budget = 20;
      while (req_count - start < budget) begin
        if (phase == 1 && !held && req_count - start >= budget / 2) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (phase == 2 && !paused && req_count - start >= budget / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        random_step();
      end
    end

    wait_idle();
    repeat (16) @(negedge clk);
    if (mismatches == 0) $display("vertical_page_bitmap_blitter verification clean");
    else $display("vertical_page_bitmap_blitter verification failed");
    $finish;
  end

endmodule

@@ vertical_page_bitmap_blitter.f @@
src/vpb_pkg.sv
src/vpb_ram.sv
src/vpb_merge.sv
src/vertical_page_bitmap_blitter.sv
tb/vpb_done_checker.sv
tb/tb_vertical_page_bitmap_blitter.sv
